### sv/itr_pkg.sv
// itr_pkg: shared constants, register codes and helpers of the tile replicator
// no dependencies; used by the interfaces and the top level

package itr_pkg;

  // default geometry limits
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_TILES_DEF  = 16;

  // fixed field widths
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int DIM_REG_W = 9;
  localparam int TILE_REG_W = 5;
  localparam int CFG_DATA_W = DIM_REG_W;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILES_ACROSS = 2'd2,
    REG_TILES_DOWN   = 2'd3
  } cfg_index_t;

  // zero reads as one, values above the limit saturate
  function automatic int unsigned clamp_reg(int unsigned v, int unsigned maxv);
    int unsigned r;
    if (v == 0) begin
      r = 1;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### sv/itr_if.sv
// itr_if: valid/ready channels of the tile replicator (pixel in, pixel out)
// depends on itr_pkg for the channel width

interface itr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [itr_pkg::CHAN_W-1:0]  red_in;
  logic [itr_pkg::CHAN_W-1:0]  green_in;
  logic [itr_pkg::CHAN_W-1:0]  blue_in;

  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface itr_out_if;
  logic                        valid;
  logic                        ready;
  logic [itr_pkg::CHAN_W-1:0]  red_out;
  logic [itr_pkg::CHAN_W-1:0]  green_out;
  logic [itr_pkg::CHAN_W-1:0]  blue_out;
  logic                        row_end;
  logic                        frame_end;

  modport source (output valid, red_out, green_out, blue_out, row_end, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, row_end, frame_end,
                  output ready);
endinterface

### sv/image_tile_replicator.sv
// image_tile_replicator: loads an RGB image into a frame store, then replays it tiled
// an accepted pull word passes through the frame store read and then the output register
// throughput: one word per cycle, loads and pulls alike; a pull word waiting on a stalled
// output holds the input; one frame store read per pull
// reset: counters cleared, registers set to 1, frame store contents left as they are
// depends on itr_pkg, itr_if (itr_in_if, itr_out_if) and itr_ram

module image_tile_replicator #(
  parameter int MAX_WIDTH  = itr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = itr_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_TILES  = itr_pkg::MAX_TILES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  itr_in_if.sink                         pix_in,
  itr_out_if.source                      pix_out,
  input  logic                           cfg_we,
  input  itr_pkg::cfg_index_t            cfg_index,
  input  logic [itr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int TW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int WV = $clog2(MAX_WIDTH + 1);
  localparam int HV = $clog2(MAX_HEIGHT + 1);
  localparam int TV = $clog2(MAX_TILES + 1);
  localparam int CH = itr_pkg::CHAN_W;
  localparam int PIX_WL = itr_pkg::PIX_W;

  // configuration registers
  logic [itr_pkg::DIM_REG_W-1:0]  image_width;
  logic [itr_pkg::DIM_REG_W-1:0]  image_height;
  logic [itr_pkg::TILE_REG_W-1:0] tiles_across;
  logic [itr_pkg::TILE_REG_W-1:0] tiles_down;

  // counters
  logic [LW-1:0] load_count;
  logic [CW-1:0] out_column;
  logic [TW-1:0] out_tile_column;
  logic [RW-1:0] out_row;
  logic [TW-1:0] out_tile_row;

  // read stage and output register
  logic          pend;
  logic          pend_row_end;
  logic          pend_frame_end;
  logic          out_valid;
  logic [CH-1:0] red_q;
  logic [CH-1:0] green_q;
  logic [CH-1:0] blue_q;
  logic          row_end_q;
  logic          frame_end_q;

  // combinational
  logic [WV-1:0]    w;
  logic [HV-1:0]    h;
  logic [TV-1:0]    tx;
  logic [TV-1:0]    ty;
  logic [WV+HV-1:0] total_full;
  logic [LW-1:0]    total;
  logic [CW-1:0]    col_eff;
  logic [TW-1:0]    tcol_eff;
  logic [RW-1:0]    row_eff;
  logic [TW-1:0]    trow_eff;
  logic [RW+WV-1:0] addr_full;
  logic [AW-1:0]    raddr;
  logic             row_end;
  logic             frame_end;
  logic             out_free;
  logic             in_acc;
  logic             load_ok;
  logic             pull_ok;
  logic [WV-1:0]    col_inc;
  logic [TV-1:0]    tcol_inc;
  logic [HV-1:0]    row_inc;
  logic [TV-1:0]    trow_inc;
  logic [PIX_WL-1:0] rdata;
  logic [CW-1:0]    out_column_next;
  logic [TW-1:0]    out_tile_column_next;
  logic [RW-1:0]    out_row_next;
  logic [TW-1:0]    out_tile_row_next;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= itr_pkg::DIM_REG_W'(1);
      image_height <= itr_pkg::DIM_REG_W'(1);
      tiles_across <= itr_pkg::TILE_REG_W'(1);
      tiles_down   <= itr_pkg::TILE_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        itr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        itr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        itr_pkg::REG_TILES_ACROSS: tiles_across <= cfg_data[itr_pkg::TILE_REG_W-1:0];
        itr_pkg::REG_TILES_DOWN:   tiles_down   <= cfg_data[itr_pkg::TILE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry and frame size
  assign w  = WV'(itr_pkg::clamp_reg(32'(image_width), MAX_WIDTH));
  assign h  = HV'(itr_pkg::clamp_reg(32'(image_height), MAX_HEIGHT));
  assign tx = TV'(itr_pkg::clamp_reg(32'(tiles_across), MAX_TILES));
  assign ty = TV'(itr_pkg::clamp_reg(32'(tiles_down), MAX_TILES));
  assign total_full = w * h;
  assign total = LW'(total_full);

  // stale counters read as zero
  assign col_eff  = (WV'(out_column) >= w)       ? '0 : out_column;
  assign tcol_eff = (TV'(out_tile_column) >= tx) ? '0 : out_tile_column;
  assign row_eff  = (HV'(out_row) >= h)          ? '0 : out_row;
  assign trow_eff = (TV'(out_tile_row) >= ty)    ? '0 : out_tile_row;

  // read address and end marks
  assign addr_full = row_eff * w + (RW+WV)'(col_eff);
  assign raddr     = AW'(addr_full);
  assign row_end   = (WV'(col_eff) == w - WV'(1)) && (TV'(tcol_eff) == tx - TV'(1));
  assign frame_end = row_end && (HV'(row_eff) == h - HV'(1)) &&
                     (TV'(trow_eff) == ty - TV'(1));

  // handshake
  assign out_free     = !out_valid || pix_out.ready;
  assign pix_in.ready = !pend || out_free;
  assign in_acc  = pix_in.valid && pix_in.ready;
  assign load_ok = in_acc && (pix_in.func == itr_pkg::FUNC_LOAD) && (load_count < total);
  assign pull_ok = in_acc && (pix_in.func == itr_pkg::FUNC_PULL) && (load_count >= total);

  // frame store
  itr_ram #(
    .WIDTH (PIX_WL),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_ok),
    .waddr (AW'(load_count)),
    .wdata ({pix_in.red_in, pix_in.green_in, pix_in.blue_in}),
    .re    (pull_ok),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next emit position in raster order of the tiled image
  assign col_inc  = WV'(col_eff) + WV'(1);
  assign tcol_inc = TV'(tcol_eff) + TV'(1);
  assign row_inc  = HV'(row_eff) + HV'(1);
  assign trow_inc = TV'(trow_eff) + TV'(1);

  always_comb begin
    out_column_next      = col_eff;
    out_tile_column_next = tcol_eff;
    out_row_next         = row_eff;
    out_tile_row_next    = trow_eff;
    if (frame_end) begin
      out_column_next      = '0;
      out_tile_column_next = '0;
      out_row_next         = '0;
      out_tile_row_next    = '0;
    end else if (col_inc < w) begin
      out_column_next = CW'(col_inc);
    end else begin
      out_column_next = '0;
      if (tcol_inc < tx) begin
        out_tile_column_next = TW'(tcol_inc);
      end else begin
        out_tile_column_next = '0;
        if (row_inc < h) begin
          out_row_next = RW'(row_inc);
        end else begin
          out_row_next = '0;
          out_tile_row_next = (trow_inc < ty) ? TW'(trow_inc) : '0;
        end
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count      <= '0;
      out_column      <= '0;
      out_tile_column <= '0;
      out_row         <= '0;
      out_tile_row    <= '0;
    end else if (load_ok) begin
      load_count <= load_count + LW'(1);
    end else if (pull_ok) begin
      if (frame_end) begin
        load_count <= '0;
      end
      out_column      <= out_column_next;
      out_tile_column <= out_tile_column_next;
      out_row         <= out_row_next;
      out_tile_row    <= out_tile_row_next;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (pull_ok) begin
      pend <= 1'b1;
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pull_ok) begin
      pend_row_end   <= row_end;
      pend_frame_end <= frame_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      red_q       <= rdata[3*CH-1:2*CH];
      green_q     <= rdata[2*CH-1:CH];
      blue_q      <= rdata[CH-1:0];
      row_end_q   <= pend_row_end;
      frame_end_q <= pend_frame_end;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.red_out   = red_q;
  assign pix_out.green_out = green_q;
  assign pix_out.blue_out  = blue_q;
  assign pix_out.row_end   = row_end_q;
  assign pix_out.frame_end = frame_end_q;

endmodule

### sv/itr_ram.sv
// itr_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module itr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
